// File: rtl/core/hrfp_pkg.sv
package hrfp_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [5:0] PAYLOAD_MAX = 6'd61;

    localparam logic [7:0] TYPE_MASK = 8'h07;
    localparam logic [7:0] ACK_BIT   = 8'h08;
    localparam logic [7:0] FRAG_BIT  = 8'h10;
    localparam logic [7:0] LEN_MASK  = 8'h3F;
    localparam logic [7:0] LINE_FEED = 8'h0A;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_LEN = 1'b1;

    typedef struct packed {
        logic [7:0]  node_id;
        logic [15:0] module_id;
        logic [7:0]  rssi;
        logic [7:0]  flags;
        logic [7:0]  frame_id;
        logic [7:0]  payload_byte;
        logic [5:0]  byte_index;
        logic        last;
        logic        status;
    } hrfp_entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } hrfp_qstat_t;

endpackage

// File: rtl/core/hrfp_front.sv
module hrfp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_char,
    input  hrfp_pkg::hrfp_qstat_t qstat,
    output logic                 push,
    output hrfp_pkg::hrfp_entry_t push_entry
);
    import hrfp_pkg::*;

    localparam logic [3:0] PH_NODE    = 4'd0;
    localparam logic [3:0] PH_SEP1    = 4'd1;
    localparam logic [3:0] PH_MOD     = 4'd2;
    localparam logic [3:0] PH_SEP2    = 4'd3;
    localparam logic [3:0] PH_RSSI    = 4'd4;
    localparam logic [3:0] PH_SEP3    = 4'd5;
    localparam logic [3:0] PH_LEN     = 4'd6;
    localparam logic [3:0] PH_SEP4    = 4'd7;
    localparam logic [3:0] PH_FLAGS   = 4'd8;
    localparam logic [3:0] PH_SEP5    = 4'd9;
    localparam logic [3:0] PH_FID     = 4'd10;
    localparam logic [3:0] PH_PSEP    = 4'd11;
    localparam logic [3:0] PH_PBYTE   = 4'd12;
    localparam logic [3:0] PH_DISCARD = 4'd13;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, c[3:0]};
            end
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  digit_count_reg, digit_count_next;
    logic [15:0] acc_reg, acc_next;
    logic        stopped_reg, stopped_next;
    logic [7:0]  node_id_reg, node_id_next;
    logic [15:0] module_id_reg, module_id_next;
    logic [7:0]  rssi_reg, rssi_next;
    logic [5:0]  length_reg, length_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  frame_id_reg, frame_id_next;
    logic [5:0]  pcount_reg, pcount_next;

    logic        take;
    logic [4:0]  hex;
    logic [15:0] acc_upd;
    logic        stopped_upd;
    logic [2:0]  cnt_upd;
    logic [2:0]  field_size;
    logic        field_done;
    logic [5:0]  pcount_inc;
    logic        bad_len;

    assign in_stall = qstat.full;
    assign take     = in_valid && !qstat.full;

    always_comb
    begin
        hex         = hex_decode(rx_char);
        acc_upd     = (!stopped_reg && hex[4]) ? {acc_reg[11:0], hex[3:0]} : acc_reg;
        stopped_upd = stopped_reg || !hex[4];
        cnt_upd     = digit_count_reg + 3'd1;
        field_size  = (phase_reg == PH_MOD) ? 3'd4 : 3'd2;
        field_done  = cnt_upd >= field_size;
        pcount_inc  = pcount_reg + 6'd1;
        bad_len     = (length_reg == 6'd0) || (length_reg > PAYLOAD_MAX);

        phase_next       = phase_reg;
        digit_count_next = digit_count_reg;
        acc_next         = acc_reg;
        stopped_next     = stopped_reg;
        node_id_next     = node_id_reg;
        module_id_next   = module_id_reg;
        rssi_next        = rssi_reg;
        length_next      = length_reg;
        flags_next       = flags_reg;
        frame_id_next    = frame_id_reg;
        pcount_next      = pcount_reg;
        push             = 1'b0;

        push_entry.node_id      = node_id_reg;
        push_entry.module_id    = module_id_reg;
        push_entry.rssi         = rssi_reg;
        push_entry.flags        = flags_reg;
        push_entry.frame_id     = frame_id_reg;
        push_entry.payload_byte = acc_upd[7:0];
        push_entry.byte_index   = pcount_reg;
        push_entry.last         = 1'b0;
        push_entry.status       = STATUS_OK;

        if (take)
        begin
            case (phase_reg)
                PH_NODE, PH_MOD, PH_RSSI, PH_LEN, PH_FLAGS, PH_FID, PH_PBYTE:
                begin
                    if (field_done)
                    begin
                        digit_count_next = 3'd0;
                        acc_next         = 16'd0;
                        stopped_next     = 1'b0;
                        phase_next       = phase_reg + 4'd1;
                        case (phase_reg)
                            PH_NODE:  node_id_next   = acc_upd[7:0];
                            PH_MOD:   module_id_next = acc_upd;
                            PH_RSSI:  rssi_next      = acc_upd[7:0];
                            PH_LEN:   length_next    = acc_upd[5:0] & LEN_MASK[5:0];
                            PH_FLAGS: flags_next     = acc_upd[7:0];
                            PH_FID:
                            begin
                                frame_id_next       = acc_upd[7:0];
                                pcount_next         = 6'd0;
                                push_entry.frame_id = acc_upd[7:0];
                                if (bad_len)
                                begin
                                    phase_next              = PH_DISCARD;
                                    push                    = 1'b1;
                                    push_entry.payload_byte = 8'd0;
                                    push_entry.byte_index   = 6'd0;
                                    push_entry.last         = 1'b1;
                                    push_entry.status       = STATUS_BAD_LEN;
                                end
                            end
                            default:
                            begin
                                pcount_next     = pcount_inc;
                                push            = 1'b1;
                                push_entry.last = (pcount_inc == length_reg);
                                phase_next      = (pcount_inc == length_reg) ? PH_DISCARD
                                                                             : PH_PSEP;
                            end
                        endcase
                    end
                    else
                    begin
                        digit_count_next = cnt_upd;
                        acc_next         = acc_upd;
                        stopped_next     = stopped_upd;
                    end
                end
                PH_SEP1, PH_SEP2, PH_SEP3, PH_SEP4, PH_SEP5:
                begin
                    phase_next = phase_reg + 4'd1;
                end
                PH_PSEP:
                begin
                    phase_next = PH_PBYTE;
                end
                default:
                begin
                    if (rx_char == LINE_FEED)
                    begin
                        digit_count_next = 3'd0;
                        acc_next         = 16'd0;
                        stopped_next     = 1'b0;
                        phase_next       = PH_NODE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_NODE;
            digit_count_reg <= 3'd0;
            acc_reg         <= 16'd0;
            stopped_reg     <= 1'b0;
            node_id_reg     <= 8'd0;
            module_id_reg   <= 16'd0;
            rssi_reg        <= 8'd0;
            length_reg      <= 6'd0;
            flags_reg       <= 8'd0;
            frame_id_reg    <= 8'd0;
            pcount_reg      <= 6'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            digit_count_reg <= digit_count_next;
            acc_reg         <= acc_next;
            stopped_reg     <= stopped_next;
            node_id_reg     <= node_id_next;
            module_id_reg   <= module_id_next;
            rssi_reg        <= rssi_next;
            length_reg      <= length_next;
            flags_reg       <= flags_next;
            frame_id_reg    <= frame_id_next;
            pcount_reg      <= pcount_next;
        end
    end

endmodule

// File: rtl/core/hrfp_queue.sv
module hrfp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hrfp_pkg::hrfp_entry_t push_entry,
    input  logic                  pop,
    output hrfp_pkg::hrfp_entry_t head_entry,
    output hrfp_pkg::hrfp_qstat_t qstat
);
    import hrfp_pkg::*;

    hrfp_entry_t       slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign qstat.full      = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.not_empty = (count_reg != '0);
    assign do_push         = push && !qstat.full;
    assign do_pop          = pop && qstat.not_empty;
    assign head_entry      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count exceeds depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !push)
        else $error("transaction pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.not_empty |-> !pop)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

// File: rtl/core/hrfp_back.sv
module hrfp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hrfp_pkg::hrfp_qstat_t qstat,
    input  hrfp_pkg::hrfp_entry_t head_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            node_id,
    output logic [15:0]           module_id,
    output logic [7:0]            rssi,
    output logic [2:0]            packet_type,
    output logic                  ack_requested,
    output logic                  fragmented,
    output logic [7:0]            frame_id,
    output logic [7:0]            payload_byte,
    output logic [5:0]            byte_index,
    output logic                  last,
    output logic                  status
);
    import hrfp_pkg::*;

    logic        valid_reg, valid_next;
    hrfp_entry_t data_reg;
    logic [7:0]  flags;

    assign pop        = qstat.not_empty && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head_entry;
        end
    end

    assign flags         = data_reg.flags;
    assign out_valid     = valid_reg;
    assign node_id       = data_reg.node_id;
    assign module_id     = data_reg.module_id;
    assign rssi          = data_reg.rssi;
    assign packet_type   = flags[2:0] & TYPE_MASK[2:0];
    assign ack_requested = |(flags & ACK_BIT);
    assign fragmented    = |(flags & FRAG_BIT);
    assign frame_id      = data_reg.frame_id;
    assign payload_byte  = data_reg.payload_byte;
    assign byte_index    = data_reg.byte_index;
    assign last          = data_reg.last;
    assign status        = data_reg.status;

endmodule

// File: rtl/core/hex_radio_frame_receive_parser_top.sv
// A result passes through a queue slot, written when the character completing its field
// is accepted, and then the output register, which loads it when the queue is popped.
// Throughput: one character per cycle; in_stall rises only while the four-entry
// result queue between parser and output register is full.
// Reset (rst_n low, asynchronous): parser returns to the node id field, all held
// header fields clear, queue empties and out_valid drops.
module hex_radio_frame_receive_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  node_id,
    output logic [15:0] module_id,
    output logic [7:0]  rssi,
    output logic [2:0]  packet_type,
    output logic        ack_requested,
    output logic        fragmented,
    output logic [7:0]  frame_id,
    output logic [7:0]  payload_byte,
    output logic [5:0]  byte_index,
    output logic        last,
    output logic        status
);
    import hrfp_pkg::*;

    hrfp_qstat_t qstat;
    hrfp_entry_t push_entry;
    hrfp_entry_t head_entry;
    logic        push;
    logic        pop;

    hrfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_char    (rx_char),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    hrfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .qstat      (qstat)
    );

    hrfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .qstat         (qstat),
        .head_entry    (head_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .node_id       (node_id),
        .module_id     (module_id),
        .rssi          (rssi),
        .packet_type   (packet_type),
        .ack_requested (ack_requested),
        .fragmented    (fragmented),
        .frame_id      (frame_id),
        .payload_byte  (payload_byte),
        .byte_index    (byte_index),
        .last          (last),
        .status        (status)
    );

endmodule
